// ===== sv/ccv_pkg.sv =====
// Shared types and constants for the character-cell video pixel generator.
`default_nettype none

package ccv_pkg;

	typedef enum logic [1:0] {
		FUNC_MAP    = 2'd0,
		FUNC_PAT    = 2'd1,
		FUNC_COLOR  = 2'd2,
		FUNC_RENDER = 2'd3
	} func_t;

	localparam int MapDepth   = 1024;
	localparam int PatDepth   = 2048;
	localparam int ColorDepth = 32;

	localparam int MapAw   = $clog2(MapDepth);
	localparam int PatAw   = $clog2(PatDepth);
	localparam int ColorAw = $clog2(ColorDepth);

	localparam int CfgIdxW  = 1;
	localparam int CfgDataW = 2;

	localparam logic [CfgIdxW-1:0] CFG_PALETTE_BANK = 1'd0;
	localparam logic [CfgIdxW-1:0] CFG_COLOR_MODE   = 1'd1;

	// Pixel position, carried down the pipe.
	typedef struct packed {
		logic [7:0] x;
		logic [7:0] y;
	} pos_t;

	// Render data handed to the shading stage.
	typedef struct packed {
		logic       valid;
		pos_t       pos;
		logic       color_mode;
	} shade_ctl_t;

endpackage

`default_nettype wire

// ===== sv/ccv_if.sv =====
// Valid/ready channel interfaces for input items and rendered pixels.
`default_nettype none

interface ccv_in_if;
	logic              valid;
	logic              ready;
	ccv_pkg::func_t    func;
	logic [10:0]       addr;
	logic [7:0]        wdata;
	logic [7:0]        px;
	logic [7:0]        py;

	modport source (output valid, output func, output addr, output wdata,
		output px, output py, input ready);
	modport sink (input valid, input func, input addr, input wdata,
		input px, input py, output ready);
endinterface

interface ccv_out_if;
	logic       valid;
	logic       ready;
	logic       red_on;
	logic       green_on;
	logic       blue_on;
	logic [7:0] out_x;
	logic [7:0] out_y;

	modport source (output valid, output red_on, output green_on, output blue_on,
		output out_x, output out_y, input ready);
	modport sink (input valid, input red_on, input green_on, input blue_on,
		input out_x, input out_y, output ready);
endinterface

`default_nettype wire

// ===== sv/ccv_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ccv_ram #(
	parameter int Width = 8,
	parameter int Depth = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output      logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== sv/ccv_shade.sv =====
// Final pipeline stage: pick the pixel bit, map it to a color, register the result.
`default_nettype none

module ccv_shade (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                advance,
	input  wire ccv_pkg::shade_ctl_t ctl_s2,
	input  wire logic [7:0]          line_s2,
	input  wire logic [7:0]          entry_s2,
	output      logic                valid_s3,
	output      logic [2:0]          color_s3,
	output      ccv_pkg::pos_t       pos_s3
);
	import ccv_pkg::*;

	logic       pix_bit;
	logic [2:0] color;

	// Leftmost pixel of the cell is the MSB of the pattern line.
	assign pix_bit = line_s2[3'd7 - ctl_s2.pos.x[2:0]];

	always_comb begin
		if (ctl_s2.color_mode) begin
			color = pix_bit ? entry_s2[7:5] : entry_s2[3:1];
		end else begin
			color = {3{pix_bit}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s3 <= ctl_s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			color_s3 <= color;
			pos_s3   <= ctl_s2.pos;
		end
	end

endmodule

`default_nettype wire

// ===== sv/char_cell_video_pixel_gen_unit.sv =====
// Top level of the character-cell video pixel generator.
//
// Usage:
//  - pix_in takes one item per transfer: func selects a tile map write, a pattern
//    store write, a color table write or a pixel render at (px, py).
//  - pix_out carries one transfer per render item: the three gun bits and the
//    pixel position. Write items give no output.
//  - cfg_we/cfg_index/cfg_wdata set palette_bank (index 0) and color_mode
//    (index 1); write them only while the pipeline is empty.
// Timing:
//  - Three register stages: tile map read, pattern/color table read, shading.
//    A render passes stage 1, stage 2 and the shading register to pix_out.
//  - One item per cycle unless pix_out stalls; the memories have registered reads
//    with one write port each, so each store read and write share the same stage.
// Reset: arst_n clears valid bits and the configuration registers; the stores
//  are not cleared and must be loaded before rendering.
// Stall: while pix_out holds a result that is not taken, the whole pipeline
//  holds and pix_in.ready drops; nothing is lost or repeated.
`default_nettype none

module char_cell_video_pixel_gen_unit (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [ccv_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [ccv_pkg::CfgDataW-1:0] cfg_wdata,
	ccv_in_if.sink                            pix_in,
	ccv_out_if.source                         pix_out
);
	import ccv_pkg::*;

	logic [1:0] bank_q;
	logic       mode_q;

	logic advance;
	logic in_xfer;

	// Stage 1 registers
	logic        valid_s1;
	func_t       func_s1;
	logic [10:0] addr_s1;
	logic [7:0]  wdata_s1;
	pos_t        pos_s1;

	// Stage 2 registers
	shade_ctl_t  ctl_s2;

	logic [7:0]  code;
	logic [7:0]  line_s2;
	logic [7:0]  entry_s2;

	logic        map_we;
	logic        pat_we;
	logic        color_we;
	logic        s1_xfer;

	logic        valid_s3;
	logic [2:0]  color_s3;
	pos_t        pos_s3;

	// Advance the whole pipe unless a finished pixel is held at the output.
	assign advance      = !valid_s3 || pix_out.ready;
	assign pix_in.ready = advance;
	assign in_xfer      = pix_in.valid && advance;
	assign s1_xfer      = valid_s1 && advance;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q <= '0;
			mode_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PALETTE_BANK: bank_q <= cfg_wdata[1:0];
				CFG_COLOR_MODE:   mode_q <= cfg_wdata[0];
				default:          ;
			endcase
		end
	end

	// Stage 0 -> 1: tile map write or lookup of the cell code.
	assign map_we = in_xfer && pix_in.func == FUNC_MAP
		&& pix_in.addr[10:MapAw] == '0;

	ccv_ram #(.Width(8), .Depth(MapDepth)) u_map (
		.clk   (clk),
		.we    (map_we),
		.waddr (pix_in.addr[MapAw-1:0]),
		.wdata (pix_in.wdata),
		.re    (advance),
		.raddr ({pix_in.py[7:3], pix_in.px[7:3]}),
		.rdata (code)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= pix_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			func_s1   <= pix_in.func;
			addr_s1   <= pix_in.addr;
			wdata_s1  <= pix_in.wdata;
			pos_s1.x  <= pix_in.px;
			pos_s1.y  <= pix_in.py;
		end
	end

	// Stage 1 -> 2: pattern line and color table entry for the code.
	assign pat_we   = s1_xfer && func_s1 == FUNC_PAT;
	assign color_we = s1_xfer && func_s1 == FUNC_COLOR
		&& addr_s1[10:ColorAw] == '0;

	ccv_ram #(.Width(8), .Depth(PatDepth)) u_pat (
		.clk   (clk),
		.we    (pat_we),
		.waddr (addr_s1[PatAw-1:0]),
		.wdata (wdata_s1),
		.re    (advance),
		.raddr ({code, pos_s1.y[2:0]}),
		.rdata (line_s2)
	);

	ccv_ram #(.Width(8), .Depth(ColorDepth)) u_color (
		.clk   (clk),
		.we    (color_we),
		.waddr (addr_s1[ColorAw-1:0]),
		.wdata (wdata_s1),
		.re    (advance),
		.raddr ({bank_q, code[7:5]}),
		.rdata (entry_s2)
	);

	// Drop write items here; only renders go on to the shading stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (advance) begin
			ctl_s2.valid      <= valid_s1 && func_s1 == FUNC_RENDER;
			ctl_s2.pos        <= pos_s1;
			ctl_s2.color_mode <= mode_q;
		end
	end

	ccv_shade u_shade (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.ctl_s2   (ctl_s2),
		.line_s2  (line_s2),
		.entry_s2 (entry_s2),
		.valid_s3 (valid_s3),
		.color_s3 (color_s3),
		.pos_s3   (pos_s3)
	);

	assign pix_out.valid    = valid_s3;
	assign pix_out.red_on   = color_s3[2];
	assign pix_out.blue_on  = color_s3[1];
	assign pix_out.green_on = color_s3[0];
	assign pix_out.out_x    = pos_s3.x;
	assign pix_out.out_y    = pos_s3.y;

endmodule

`default_nettype wire
